[sv/scra_pkg.sv]
package scra_pkg;

  localparam int HEAP_BYTES   = 65536;
  localparam int SIZE_CLASSES = 256;
  localparam int STORE_DEPTH  = HEAP_BYTES / 8;
  localparam int IDX_W        = $clog2(STORE_DEPTH);
  localparam int CLS_W        = $clog2(SIZE_CLASSES);
  localparam int BP_W         = 17;
  localparam int ADDR_W       = 16;
  localparam int SIZE_W       = 16;
  localparam int CMD_W        = 3;
  localparam int ST_W         = 4;
  localparam int HDR_W        = 48;

  localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ATTACH    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DETACH    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PREDETACH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GUARD     = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 4'd0;
  localparam logic [ST_W-1:0] ST_LAST     = 4'd1;
  localparam logic [ST_W-1:0] ST_COPY     = 4'd2;
  localparam logic [ST_W-1:0] ST_BAD_SIZE = 4'd3;
  localparam logic [ST_W-1:0] ST_TOO_BIG  = 4'd4;
  localparam logic [ST_W-1:0] ST_OOM      = 4'd5;
  localparam logic [ST_W-1:0] ST_FREE_OBJ = 4'd6;
  localparam logic [ST_W-1:0] ST_UNINIT   = 4'd7;
  localparam logic [ST_W-1:0] ST_CONST    = 4'd8;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 4'd9;

  localparam logic [15:0]     COUNT_ONE     = 16'h0001;
  localparam logic [15:0]     GUARD_PAIR    = 16'h4002;
  localparam logic [13:0]     CNT_FIELD_MAX = 14'h3FFF;
  localparam logic [BP_W-1:0] BP_RESET      = 17'd16;

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_HDAT, S_ASZ, S_AHD, S_APOP, S_FPSH, S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic dispatch;
    logic hdata;
    logic a_size;
    logic a_head;
    logic a_pop;
    logic f_push;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic imm_done;
    logic go_alloc;
    logic h_alloc;
    logic h_free;
    logic a_err;
    logic a_hit;
    logic out_free;
  } sts_t;

endpackage

[sv/scra_ctrl.sv]
module scra_ctrl import scra_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output logic in_stall,
  output ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        if (sts.imm_done)      state_nxt = S_DONE;
        else if (sts.go_alloc) state_nxt = S_ASZ;
        else                   state_nxt = S_HDAT;
      end
      S_HDAT: begin
        if (sts.h_alloc)     state_nxt = S_ASZ;
        else if (sts.h_free) state_nxt = S_FPSH;
        else                 state_nxt = S_DONE;
      end
      S_ASZ:  state_nxt = sts.a_err ? S_DONE : S_AHD;
      S_AHD:  state_nxt = sts.a_hit ? S_APOP : S_DONE;
      S_APOP: state_nxt = S_DONE;
      S_FPSH: state_nxt = S_DONE;
      S_DONE: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: ctl.capture  = in_valid;
      S_DISP: ctl.dispatch = 1'b1;
      S_HDAT: ctl.hdata    = 1'b1;
      S_ASZ:  ctl.a_size   = 1'b1;
      S_AHD:  ctl.a_head   = 1'b1;
      S_APOP: ctl.a_pop    = 1'b1;
      S_FPSH: ctl.f_push   = 1'b1;
      S_DONE: ctl.finish   = sts.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

[sv/scra_dp.sv]
module scra_dp import scra_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [SIZE_W-1:0] in_size,
  input  logic              out_stall,
  output sts_t              sts,
  output logic              out_valid,
  output logic [15:0]       out_result_addr,
  output logic [15:0]       out_object_length,
  output logic [ST_W-1:0]   out_status
);

  logic [HDR_W-1:0]  hdr_mem [STORE_DEPTH];
  logic [15:0]       fh_mem  [SIZE_CLASSES];
  logic [SIZE_CLASSES-1:0] fh_vld_r;

  logic [CMD_W-1:0]  cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SIZE_W-1:0] size_r;
  logic [HDR_W-1:0]  hdr_rd_r;
  logic              hq_ok_r;
  logic [15:0]       fh_q_r;
  logic              fh_v_r;
  logic [SIZE_W-1:0] asize_r;
  logic [15:0]       acnt_r;
  logic [ST_W-1:0]   asucc_r;
  logic [15:0]       afail_len_r;
  logic [CLS_W-1:0]  cls_r;
  logic [15:0]       objlen_r;
  logic [BP_W-1:0]   offset_r;
  logic [BP_W-1:0]   bp_r;
  logic [15:0]       head_r;
  logic [15:0]       res_r, len_r;
  logic [ST_W-1:0]   st_r;
  logic              out_valid_r;
  logic [15:0]       out_res_r, out_len_r;
  logic [ST_W-1:0]   out_st_r;

  logic [15:0] obj;
  logic        obj_in;
  assign obj    = {addr_r[15:3], 3'b000};
  assign obj_in = ({1'b0, addr_r} < 17'(HEAP_BYTES));

  // dispatch decode
  logic            d_imm, d_alloc;
  logic [15:0]     d_res;
  logic [ST_W-1:0] d_st;

  always_comb begin
    d_imm   = 1'b0;
    d_alloc = 1'b0;
    d_res   = '0;
    d_st    = ST_OK;
    case (cmd_r)
      CMD_ALLOC: d_alloc = 1'b1;
      CMD_ATTACH: begin
        if (addr_r == 16'd0) begin
          d_imm = 1'b1;
          d_st  = ST_UNINIT;
        end else if (addr_r == 16'd1) begin
          d_imm = 1'b1;
          d_res = 16'd1;
        end
      end
      CMD_DETACH, CMD_PREDETACH: d_imm = (addr_r < 16'd2);
      CMD_GUARD: begin
        if (addr_r == 16'd1) begin
          d_imm = 1'b1;
          d_res = 16'd1;
        end else if (addr_r == 16'd0) begin
          d_alloc = 1'b1;
        end
      end
      default: d_imm = 1'b1;
    endcase
  end

  // header decision
  logic [HDR_W-1:0] h;
  logic [15:0]      h_cnt, h_len, h_dec, h_inc;
  logic             h_full;
  logic             hx_wr, hx_alloc, hx_free;
  logic [15:0]      hx_cnt, hx_res, hx_asize, hx_acnt;
  logic [ST_W-1:0]  hx_st;

  assign h      = hq_ok_r ? hdr_rd_r : '0;
  assign h_cnt  = h[47:32];
  assign h_len  = h[31:16];
  assign h_inc  = h_cnt + 16'd1;
  assign h_dec  = h_cnt - 16'd1;
  assign h_full = (h_cnt[13:0] == CNT_FIELD_MAX);

  always_comb begin
    hx_wr    = 1'b0;
    hx_alloc = 1'b0;
    hx_free  = 1'b0;
    hx_cnt   = h_inc;
    hx_res   = '0;
    hx_st    = ST_OK;
    hx_asize = h_len;
    hx_acnt  = COUNT_ONE;
    case (cmd_r)
      CMD_ATTACH: begin
        if (h_cnt[15]) begin
          hx_res = obj;
        end else if (h_cnt == 16'd0) begin
          hx_st = ST_FREE_OBJ;
        end else if (!h_cnt[14]) begin
          if (h_full) begin
            hx_st = ST_OVERFLOW;
          end else begin
            hx_wr  = 1'b1;
            hx_res = obj;
          end
        end else begin
          hx_alloc = 1'b1;
        end
      end
      CMD_DETACH, CMD_PREDETACH: begin
        if (h_cnt[15]) begin
          hx_st = ST_OK;
        end else if (h_cnt == 16'd0) begin
          hx_st = ST_FREE_OBJ;
        end else if (h_cnt != 16'd1) begin
          hx_wr  = 1'b1;
          hx_cnt = (h_dec[13:0] == 14'd1) ? COUNT_ONE : h_dec;
        end else if (cmd_r == CMD_PREDETACH) begin
          hx_res = obj;
          hx_st  = ST_LAST;
        end else if (h_len[15:3] > 13'(SIZE_CLASSES - 1)) begin
          hx_st = ST_TOO_BIG;
        end else begin
          hx_free = 1'b1;
        end
      end
      CMD_GUARD: begin
        if (h_cnt[15]) begin
          hx_st = ST_CONST;
        end else if (h_cnt == 16'd0) begin
          hx_st = ST_FREE_OBJ;
        end else if (h_cnt == 16'd1) begin
          hx_wr  = 1'b1;
          hx_cnt = GUARD_PAIR;
          hx_res = obj;
        end else if (h_cnt[14]) begin
          if (h_full) begin
            hx_st = ST_OVERFLOW;
          end else begin
            hx_wr  = 1'b1;
            hx_res = obj;
          end
        end else begin
          hx_alloc = 1'b1;
          hx_asize = size_r;
          hx_acnt  = GUARD_PAIR;
        end
      end
      default: hx_st = ST_OK;
    endcase
  end

  // size class rounding
  logic [17:0]      msize_raw, msize, offset18, objlen18;
  logic [CLS_W-1:0] a_cls;
  logic             a_err;
  logic [ST_W-1:0]  a_err_st;

  always_comb begin
    msize_raw = ({2'b00, asize_r} + 18'd3) & ~18'd3;
    msize     = (msize_raw < 18'd8) ? 18'd8 : msize_raw;
    offset18  = (msize + 18'd11) & ~18'd7;
    objlen18  = offset18 - 18'd4;
    a_cls     = objlen18[3 +: CLS_W];
    a_err     = 1'b1;
    a_err_st  = ST_BAD_SIZE;
    if (asize_r == 16'd0 || objlen18[17:16] != 2'b00) begin
      a_err_st = ST_BAD_SIZE;
    end else if (objlen18[17:3] > 15'(SIZE_CLASSES - 1)) begin
      a_err_st = ST_TOO_BIG;
    end else begin
      a_err = 1'b0;
    end
  end

  logic [15:0] head;
  logic [17:0] bump_sum;
  logic        bump_full;
  assign head      = fh_v_r ? fh_q_r : 16'd0;
  assign bump_sum  = {1'b0, bp_r} + {1'b0, offset_r};
  assign bump_full = (bump_sum > 18'(HEAP_BYTES));

  // header store write port
  logic             hw_en;
  logic [IDX_W-1:0] hw_idx;
  logic [HDR_W-1:0] hw_data;

  always_comb begin
    hw_en   = 1'b0;
    hw_idx  = addr_r[3 +: IDX_W];
    hw_data = {hx_cnt, h_len, h[15:0]};
    if (ctl.hdata) begin
      hw_en = hx_wr && hq_ok_r;
    end else if (ctl.a_head) begin
      hw_en   = (head == 16'd0) && !bump_full;
      hw_idx  = bp_r[3 +: IDX_W];
      hw_data = {acnt_r, objlen_r, 16'd0};
    end else if (ctl.a_pop) begin
      hw_en   = 1'b1;
      hw_idx  = head_r[3 +: IDX_W];
      hw_data = {acnt_r, objlen_r, 16'd0};
    end else if (ctl.f_push) begin
      hw_en   = obj_in;
      hw_data = {16'd0, len_r, head};
    end
  end

  logic [IDX_W-1:0] hr_idx;
  logic [CLS_W-1:0] fr_cls;
  assign hr_idx = ctl.a_head ? head[3 +: IDX_W] : addr_r[3 +: IDX_W];
  assign fr_cls = ctl.hdata ? h_len[3 +: CLS_W] : a_cls;

  always_ff @(posedge clk) begin
    if (hw_en) hdr_mem[hw_idx] <= hw_data;
    if (ctl.dispatch || ctl.a_head) hdr_rd_r <= hdr_mem[hr_idx];
    if (ctl.a_pop)  fh_mem[cls_r] <= hdr_rd_r[15:0];
    if (ctl.f_push) fh_mem[cls_r] <= obj;
    if (ctl.hdata || ctl.a_size) fh_q_r <= fh_mem[fr_cls];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fh_vld_r    <= '0;
      bp_r        <= BP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.a_pop || (ctl.f_push && obj_in)) fh_vld_r[cls_r] <= 1'b1;
      if (ctl.a_head && head == 16'd0 && !bump_full) bp_r <= bump_sum[BP_W-1:0];
      if (ctl.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= in_command;
      addr_r <= in_addr;
      size_r <= in_size;
    end
    if (ctl.dispatch) begin
      hq_ok_r     <= obj_in;
      res_r       <= d_res;
      len_r       <= '0;
      st_r        <= d_st;
      asize_r     <= size_r;
      acnt_r      <= (cmd_r == CMD_GUARD) ? GUARD_PAIR : COUNT_ONE;
      asucc_r     <= ST_OK;
      afail_len_r <= '0;
    end
    if (ctl.a_head) hq_ok_r <= 1'b1;
    if (ctl.hdata || ctl.a_size) fh_v_r <= fh_vld_r[fr_cls];
    if (ctl.hdata) begin
      res_r       <= hx_res;
      len_r       <= h_len;
      st_r        <= hx_st;
      asize_r     <= hx_asize;
      acnt_r      <= hx_acnt;
      asucc_r     <= ST_COPY;
      afail_len_r <= h_len;
      cls_r       <= h_len[3 +: CLS_W];
    end
    if (ctl.a_size) begin
      if (a_err) begin
        res_r <= '0;
        len_r <= afail_len_r;
        st_r  <= a_err_st;
      end
      cls_r    <= a_cls;
      objlen_r <= objlen18[15:0];
      offset_r <= offset18[BP_W-1:0];
    end
    if (ctl.a_head) begin
      head_r <= head;
      if (head == 16'd0) begin
        if (bump_full) begin
          res_r <= '0;
          len_r <= afail_len_r;
          st_r  <= ST_OOM;
        end else begin
          res_r <= bp_r[15:0];
          len_r <= objlen_r;
          st_r  <= asucc_r;
        end
      end
    end
    if (ctl.a_pop) begin
      res_r <= head_r;
      len_r <= objlen_r;
      st_r  <= asucc_r;
    end
    if (ctl.f_push) begin
      res_r <= '0;
      st_r  <= ST_LAST;
    end
    if (ctl.finish) begin
      out_res_r <= res_r;
      out_len_r <= len_r;
      out_st_r  <= st_r;
    end
  end

  always_comb begin
    sts          = '0;
    sts.imm_done = d_imm;
    sts.go_alloc = d_alloc;
    sts.h_alloc  = hx_alloc;
    sts.h_free   = hx_free;
    sts.a_err    = a_err;
    sts.a_hit    = (head != 16'd0);
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_result_addr   = out_res_r;
  assign out_object_length = out_len_r;
  assign out_status        = out_st_r;

endmodule

[sv/size_class_refcount_allocator_top.sv]
// Longest path from accept to out_valid is attach/guard copy via free list.
// Throughput: one transaction in flight; the next is accepted the cycle after the result is
// registered. The state sequence of each transaction follows dependent header/list reads.
// Reset (rst_n low, synchronous): FSM idle, no result pending, all free lists empty,
// bump pointer at 16. Header store is not cleared; it is defined once written.
module size_class_refcount_allocator_top import scra_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [SIZE_W-1:0] in_size,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_result_addr,
  output logic [15:0]       out_object_length,
  output logic [ST_W-1:0]   out_status
);

  // controller/datapath handshake
  ctl_t ctl;
  sts_t sts;

  // sequencer: one transaction at a time
  scra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  // header store, list heads, bump pointer and result register
  scra_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .in_command        (in_command),
    .in_addr           (in_addr),
    .in_size           (in_size),
    .out_stall         (out_stall),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_result_addr   (out_result_addr),
    .out_object_length (out_object_length),
    .out_status        (out_status)
  );

  // an accepted transaction closes the input until its result is out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open after accept");

  // result register only loaded when free
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |-> (!out_valid || !out_stall))
    else $error("result overwritten");

  // at most one sequencer step per cycle
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.capture, ctl.dispatch, ctl.hdata, ctl.a_size,
              ctl.a_head, ctl.a_pop, ctl.f_push, ctl.finish}))
    else $error("overlapping steps");

  // status codes stay in range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_OVERFLOW))
    else $error("bad status");

endmodule

[sim/size_class_refcount_allocator_top_tb.sv]
`timescale 1ns / 1ps

module size_class_refcount_allocator_top_tb;
  import scra_pkg::*;

  // Codes the block ignores; result is all zeros
  localparam logic [CMD_W-1:0] CMD_IGNORED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_IGNORED_HI = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command;
  logic [ADDR_W-1:0] in_addr;
  logic [SIZE_W-1:0] in_size;
  logic              out_valid;
  logic              out_stall;
  logic [15:0]       out_result_addr;
  logic [15:0]       out_object_length;
  logic [ST_W-1:0]   out_status;

  size_class_refcount_allocator_top dut (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [15:0]     addr;
    logic [15:0]     len;
    logic [ST_W-1:0] st;
  } heap_reply_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    bit                typed;
    heap_reply_t       want;
  } heap_row_t;

  // Shadow heap: header words, list heads, bump pointer
  logic [15:0] shadow_count [STORE_DEPTH];
  logic [15:0] shadow_len   [STORE_DEPTH];
  logic [15:0] shadow_link  [STORE_DEPTH];
  bit          shadow_known [STORE_DEPTH];
  logic [15:0] shadow_heads [SIZE_CLASSES];
  int          shadow_bump;
  int          known_slots [$];

  heap_reply_t pending_replies [$];
  int          errors;
  int          sent;
  int          replies_seen;
  int          status_seen [16];

  function automatic void put_header(int obj, logic [15:0] c, logic [15:0] l, logic [15:0] lk);
    int idx;
    idx = obj >> 3;
    shadow_count[idx] = c;
    shadow_len[idx]   = l;
    shadow_link[idx]  = lk;
    if (!shadow_known[idx]) begin
      shadow_known[idx] = 1'b1;
      known_slots.push_back(idx);
    end
  endfunction

  // Size-class allocation: free list of the class first, then bump pointer
  function automatic logic [ST_W-1:0] carve(int size, output int obj, output int olen);
    int msize, span, cls;
    obj  = 0;
    olen = 0;
    if (size == 0) return ST_BAD_SIZE;
    msize = (size + 3) & ~3;
    if (msize < 8) msize = 8;
    span = (msize + 4 + 7) & ~7;
    if (span - 4 >= 65536) return ST_BAD_SIZE;
    cls = (span - 4) >> 3;
    if (cls > SIZE_CLASSES - 1) return ST_TOO_BIG;
    if (shadow_heads[cls] != 0) begin
      obj = shadow_heads[cls];
      shadow_heads[cls] = shadow_link[obj >> 3];
    end else begin
      if (shadow_bump + span > HEAP_BYTES) return ST_OOM;
      obj = shadow_bump;
      shadow_bump += span;
    end
    olen = span - 4;
    put_header(obj, COUNT_ONE, olen[15:0], 16'h0000);
    return ST_OK;
  endfunction

  function automatic heap_reply_t heap_step(logic [CMD_W-1:0] cmd, int addr, int size);
    heap_reply_t r;
    int obj, n, nl, idx, cls, olen;
    logic [15:0] c;
    logic [ST_W-1:0] st;
    r = '{16'h0, 16'h0, ST_OK};
    obj = addr & ~7;
    case (cmd)
      CMD_ALLOC: begin
        r.st = carve(size, n, nl);
        r.addr = n[15:0];
        r.len = nl[15:0];
      end
      CMD_ATTACH: begin
        if (addr == 0) r.st = ST_UNINIT;
        else if (addr == 1) r.addr = 16'h1;
        else begin
          idx = obj >> 3;
          c = shadow_count[idx];
          r.len = shadow_len[idx];
          if (c[15]) r.addr = obj[15:0];
          else if (c == 0) r.st = ST_FREE_OBJ;
          else if (!c[14]) begin
            if (c[13:0] == CNT_FIELD_MAX) r.st = ST_OVERFLOW;
            else begin
              shadow_count[idx] = c + 16'd1;
              r.addr = obj[15:0];
            end
          end else begin
            st = carve(shadow_len[idx], n, nl);
            r.st = st;
            if (st == ST_OK) begin
              r.addr = n[15:0];
              r.len = nl[15:0];
              r.st = ST_COPY;
            end
          end
        end
      end
      CMD_DETACH, CMD_PREDETACH: begin
        if (addr >= 2) begin
          idx = obj >> 3;
          c = shadow_count[idx];
          r.len = shadow_len[idx];
          if (!c[15]) begin
            if (c == 0) r.st = ST_FREE_OBJ;
            else if (c != 1) begin
              c = c - 16'd1;
              shadow_count[idx] = (c[13:0] == 14'd1) ? COUNT_ONE : c;
            end else if (cmd == CMD_PREDETACH) begin
              r.addr = obj[15:0];
              r.st = ST_LAST;
            end else begin
              cls = shadow_len[idx] >> 3;
              if (cls > SIZE_CLASSES - 1) r.st = ST_TOO_BIG;
              else begin
                shadow_count[idx] = 16'h0;
                shadow_link[idx] = shadow_heads[cls];
                shadow_heads[cls] = obj[15:0];
                r.st = ST_LAST;
              end
            end
          end
        end
      end
      CMD_GUARD: begin
        if (addr == 1) begin
          r.addr = 16'h1;
          return r;
        end
        if (addr == 0) begin
          st = carve(size, obj, olen);
          if (st != ST_OK) begin
            r.st = st;
            return r;
          end
        end
        idx = obj >> 3;
        c = shadow_count[idx];
        r.len = shadow_len[idx];
        if (c[15]) r.st = ST_CONST;
        else if (c == 0) r.st = ST_FREE_OBJ;
        else if (c == 1) begin
          shadow_count[idx] = GUARD_PAIR;
          r.addr = obj[15:0];
        end else if (c[14]) begin
          if (c[13:0] == CNT_FIELD_MAX) r.st = ST_OVERFLOW;
          else begin
            shadow_count[idx] = c + 16'd1;
            r.addr = obj[15:0];
          end
        end else begin
          st = carve(size, n, nl);
          r.st = st;
          if (st == ST_OK) begin
            shadow_count[n >> 3] = GUARD_PAIR;
            r.addr = n[15:0];
            r.len = nl[15:0];
            r.st = ST_COPY;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // One input transaction; in_valid stays high into the next one when no gap follows
  task automatic push_cmd(heap_row_t row);
    int gap;
    heap_reply_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= row.cmd;
    in_addr    <= row.addr;
    in_size    <= row.size;
    do @(posedge clk); while (in_stall);
    r = heap_step(row.cmd, row.addr, row.size);
    pending_replies.push_back(row.typed ? row.want : r);
    sent++;
  endtask

  task automatic push_plain(logic [CMD_W-1:0] cmd, int addr, int size);
    heap_row_t row;
    row = '{cmd, addr[15:0], size[15:0], 1'b0, '{16'h0, 16'h0, ST_OK}};
    push_cmd(row);
  endtask

  // Directed opening: size limits, nil/uninitialised, last reference, free list reuse
  heap_row_t opening [] = '{
    '{CMD_ALLOC,      16'h0,  16'd0,     1, '{16'd0,  16'd0,    ST_BAD_SIZE}},
    '{CMD_ALLOC,      16'h0,  16'hFFFF,  1, '{16'd0,  16'd0,    ST_BAD_SIZE}},
    '{CMD_ALLOC,      16'h0,  16'd2045,  1, '{16'd0,  16'd0,    ST_TOO_BIG}},
    '{CMD_ALLOC,      16'h0,  16'd1,     1, '{16'd16, 16'd12,   ST_OK}},
    '{CMD_ALLOC,      16'h0,  16'd2044,  1, '{16'd32, 16'd2044, ST_OK}},
    '{CMD_ATTACH,     16'h0,  16'd0,     1, '{16'd0,  16'd0,    ST_UNINIT}},
    '{CMD_ATTACH,     16'h1,  16'd0,     1, '{16'd1,  16'd0,    ST_OK}},
    '{CMD_DETACH,     16'h0,  16'd0,     1, '{16'd0,  16'd0,    ST_OK}},
    '{CMD_PREDETACH,  16'h1,  16'd0,     1, '{16'd0,  16'd0,    ST_OK}},
    '{CMD_ATTACH,     16'd21, 16'd0,     0, '{16'd0,  16'd0,    ST_OK}},
    '{CMD_PREDETACH,  16'd16, 16'd0,     0, '{16'd0,  16'd0,    ST_OK}},
    '{CMD_PREDETACH,  16'd23, 16'd0,     1, '{16'd16, 16'd12,   ST_LAST}},
    '{CMD_GUARD,      16'd16, 16'd4,     0, '{16'd0,  16'd0,    ST_OK}},
    '{CMD_ATTACH,     16'd16, 16'd0,     0, '{16'd0,  16'd0,    ST_OK}},
    '{CMD_DETACH,     16'd16, 16'd0,     0, '{16'd0,  16'd0,    ST_OK}},
    '{CMD_DETACH,     16'd16, 16'd0,     0, '{16'd0,  16'd0,    ST_OK}},
    '{CMD_DETACH,     16'd16, 16'd0,     1, '{16'd0,  16'd12,   ST_FREE_OBJ}},
    '{CMD_GUARD,      16'd16, 16'd8,     1, '{16'd0,  16'd12,   ST_FREE_OBJ}},
    '{CMD_ALLOC,      16'h0,  16'd3,     1, '{16'd16, 16'd12,   ST_OK}},
    '{CMD_GUARD,      16'h0,  16'd100,   0, '{16'd0,  16'd0,    ST_OK}},
    '{CMD_GUARD,      16'h0,  16'd0,     1, '{16'd0,  16'd0,    ST_BAD_SIZE}},
    '{CMD_GUARD,      16'h1,  16'd5,     1, '{16'd1,  16'd0,    ST_OK}},
    '{CMD_IGNORED_LO, 16'd16, 16'd8,     1, '{16'd0,  16'd0,    ST_OK}},
    '{CMD_IGNORED_HI, 16'hFFFF, 16'hFFFF, 1, '{16'd0, 16'd0,    ST_OK}}
  };

  function automatic int pick_addr();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8 || known_slots.size() == 0) return 0;
    if (p < 12) return 1;
    return (known_slots[$urandom_range(0, known_slots.size() - 1)] << 3)
           | $urandom_range(0, 7);
  endfunction

  function automatic int pick_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) return 0;
    if (p < 10) return $urandom_range(0, 65535);
    if (p < 35) return $urandom_range(1000, 2044);
    return $urandom_range(1, 64);
  endfunction

  // Result side: random stall bursts, mostly short, the odd long one
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      case ($urandom_range(0, 19))
        0, 1, 2: stall_left <= $urandom_range(1, 3);
        3:       stall_left <= $urandom_range(10, 30);
        default: stall_left <= 0;
      endcase
    end
  end

  // Result checker: oldest expectation against every accepted result transaction
  always @(posedge clk) begin
    heap_reply_t w;
    if (rst_n && out_valid && !out_stall) begin
      replies_seen++;
      status_seen[out_status]++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result addr=%h len=%h status=%0d",
                 $time, out_result_addr, out_object_length, out_status);
        errors++;
      end else begin
        w = pending_replies.pop_front();
        if (out_result_addr !== w.addr) begin
          $display("%0t: result_addr expected %h actual %h", $time, w.addr, out_result_addr);
          errors++;
        end
        if (out_object_length !== w.len) begin
          $display("%0t: object_length expected %h actual %h",
                   $time, w.len, out_object_length);
          errors++;
        end
        if (out_status !== w.st) begin
          $display("%0t: status expected %0d actual %0d", $time, w.st, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int p;
    logic [CMD_W-1:0] cmd;
    in_valid   = 1'b0;
    in_command = CMD_ALLOC;
    in_addr    = '0;
    in_size    = '0;
    rst_n      = 1'b0;
    errors     = 0;
    sent       = 0;
    replies_seen = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (shadow_known[i]) begin
      shadow_known[i] = 1'b0;
      shadow_count[i] = '0;
      shadow_len[i]   = '0;
      shadow_link[i]  = '0;
    end
    foreach (shadow_heads[i]) shadow_heads[i] = '0;
    shadow_bump = BP_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) push_cmd(opening[i]);

    // Random mix; big sizes soon exhaust the bump pointer so the free lists carry on
    repeat (400) begin
      p = $urandom_range(0, 99);
      if (p < 30)      cmd = CMD_ALLOC;
      else if (p < 45) cmd = CMD_ATTACH;
      else if (p < 65) cmd = CMD_DETACH;
      else if (p < 75) cmd = CMD_PREDETACH;
      else if (p < 97) cmd = CMD_GUARD;
      else             cmd = 3'($urandom_range(CMD_IGNORED_LO, CMD_IGNORED_HI));
      push_plain(cmd, pick_addr(), pick_size());
    end
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d transactions, %0d results; ok %0d, last ref %0d, copy %0d,",
             sent, replies_seen, status_seen[ST_OK], status_seen[ST_LAST], status_seen[ST_COPY]);
    $display("bad size %0d, too large %0d, out of memory %0d, free object %0d, overflow %0d",
             status_seen[ST_BAD_SIZE], status_seen[ST_TOO_BIG], status_seen[ST_OOM],
             status_seen[ST_FREE_OBJ], status_seen[ST_OVERFLOW]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/scra_pkg.sv
sv/scra_ctrl.sv
sv/scra_dp.sv
sv/size_class_refcount_allocator_top.sv
sim/size_class_refcount_allocator_top_tb.sv
